[design/projective_point_projection_jacobian_top_defines.svh]
// ----------------------------------------------------------------------------
// projective point projection jacobian: assertion macros
// shared concurrent assertion forms, clocked on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef PROJECTIVE_POINT_PROJECTION_JACOBIAN_TOP_DEFINES_SVH
`define PROJECTIVE_POINT_PROJECTION_JACOBIAN_TOP_DEFINES_SVH

// same-cycle implication
`define PPJ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPJ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ppj_pkg.sv]
// ----------------------------------------------------------------------------
// ppj_pkg
// types, constants and the micro-op program of the reprojection jacobian unit
// ----------------------------------------------------------------------------
`default_nettype none

package ppj_pkg;

  localparam int WordBitsDef = 32;
  localparam int FracBitsDef = 16;
  localparam int FieldBits   = 32;
  localparam int GroupBits   = 4;
  localparam int ModeBits    = 2;
  localparam int RowBits     = 2;
  localparam int AddrBits    = 6;
  localparam int MemDepth    = 64;
  localparam int PcBits      = 7;
  localparam int FifoDepth   = 2;

  localparam logic [ModeBits-1:0] MODE_LOAD = 2'd0;
  localparam logic [ModeBits-1:0] MODE_PROJ = 2'd1;
  localparam logic [ModeBits-1:0] MODE_JAC  = 2'd2;
  localparam logic [RowBits-1:0]  ROW_LAST  = 2'd2;

  typedef enum logic [1:0] {JOB_LOAD, JOB_PROJ, JOB_JAC} job_e;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_NEG, OP_RCP, OP_BZ, OP_CHK, OP_EMIT, OP_END
  } op_e;

  typedef enum logic [2:0] {AL_IDLE, AL_MUL, AL_MACC, AL_DIV, AL_FIN} al_state_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_LOAD, BK_PTWR, BK_FETCH, BK_EXEC, BK_WAIT, BK_EMIT_B, BK_EMIT_C
  } bk_state_e;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [PcBits-1:0]   pc_t;

  typedef struct packed {
    logic start;
    logic recip;
  } alu_req_t;

  typedef struct packed {
    op_e                  kind;
    addr_t                a;
    addr_t                b;
    addr_t                c;
    addr_t                d;
    addr_t                dst;
    logic [3:0]           en;
    logic [GroupBits-1:0] grp;
    pc_t                  tgt;
  } uop_t;

  // scratch memory map: camera matrix in 0..11, row-major
  localparam addr_t A_X  = 6'd12;
  localparam addr_t A_W  = 6'd15;
  localparam addr_t A_R  = 6'd16;
  localparam addr_t A_U  = 6'd17;
  localparam addr_t A_V  = 6'd18;
  localparam addr_t A_N0 = 6'd19;
  localparam addr_t A_N1 = 6'd20;
  localparam addr_t A_T  = 6'd21;
  localparam addr_t A_J1 = 6'd22;
  localparam addr_t A_J2 = 6'd25;
  localparam addr_t A_A0 = 6'd28;
  localparam addr_t A_G5 = 6'd32;
  localparam addr_t A_G8 = 6'd36;

  localparam pc_t PC_EMIT0 = 7'd22;
  localparam pc_t PC_EMIT1 = 7'd67;

  function automatic uop_t ppj_uop(input op_e k, input addr_t a, input addr_t b,
                                   input addr_t dst);
    uop_t u;
    u      = '0;
    u.kind = k;
    u.a    = a;
    u.b    = b;
    u.dst  = dst;
    return u;
  endfunction

  // one step of a row dot product: mul, add, mul, add, mul, add
  function automatic uop_t ppj_dot(input logic [2:0] j, input logic [1:0] row,
                                   input addr_t dst);
    logic [1:0] e;
    uop_t       u;
    e = j[2:1];
    if (!j[0]) begin
      u = ppj_uop(OP_MUL, addr_t'({row, e}), A_X + addr_t'(e), A_T);
    end else if (e == 2'd0) begin
      u = ppj_uop(OP_ADD, addr_t'({row, 2'd3}), A_T, dst);
    end else begin
      u = ppj_uop(OP_ADD, dst, A_T, dst);
    end
    return u;
  endfunction

  function automatic uop_t ppj_emit(input logic [GroupBits-1:0] g);
    uop_t u;
    u      = '0;
    u.kind = OP_EMIT;
    u.grp  = g;
    case (g)
      4'd0: begin
        u.a = A_U; u.b = A_V; u.en = 4'b0011;
      end
      4'd1: begin
        u.a = A_J1; u.b = A_J1 + 6'd1; u.c = A_J1 + 6'd2; u.en = 4'b0111;
      end
      4'd2: begin
        u.a = A_J2; u.b = A_J2 + 6'd1; u.c = A_J2 + 6'd2; u.en = 4'b0111;
      end
      4'd3, 4'd7: begin
        u.a = A_A0; u.b = A_A0 + 6'd1; u.c = A_A0 + 6'd2; u.d = A_R; u.en = 4'b1111;
      end
      4'd5: begin
        u.a = A_G5; u.b = A_G5 + 6'd1; u.c = A_G5 + 6'd2; u.d = A_G5 + 6'd3;
        u.en = 4'b1111;
      end
      4'd8: begin
        u.a = A_G8; u.b = A_G8 + 6'd1; u.c = A_G8 + 6'd2; u.d = A_G8 + 6'd3;
        u.en = 4'b1111;
      end
      default: u.en = 4'b0000;
    endcase
    return u;
  endfunction

  // micro-op program for one point
  function automatic uop_t ppj_prog(input pc_t pc);
    logic [4:0] j;
    logic [4:0] jj;
    logic       rsel;
    logic [1:0] k;
    addr_t      ak;
    uop_t       u;
    if (pc < 7'd6) begin
      u = ppj_dot(3'(pc), 2'd2, A_W);
    end else if (pc == 7'd6) begin
      u = ppj_uop(OP_BZ, A_W, A_W, A_W);
      u.tgt = PC_EMIT0;
    end else if (pc == 7'd7) begin
      u = ppj_uop(OP_RCP, A_W, A_W, A_R);
    end else if (pc < 7'd14) begin
      u = ppj_dot(3'(pc - 7'd8), 2'd0, A_N0);
    end else if (pc < 7'd20) begin
      u = ppj_dot(3'(pc - 7'd14), 2'd1, A_N1);
    end else if (pc == 7'd20) begin
      u = ppj_uop(OP_MUL, A_N0, A_R, A_U);
    end else if (pc == 7'd21) begin
      u = ppj_uop(OP_MUL, A_N1, A_R, A_V);
    end else if (pc == PC_EMIT0) begin
      u = ppj_emit(4'd0);
    end else if (pc == 7'd23) begin
      u = ppj_uop(OP_CHK, A_W, A_W, A_W);
      u.tgt = PC_EMIT1;
    end else if (pc < 7'd48) begin
      // point jacobian rows: (P[row][k] - u*P[2][k]) * r
      j    = 5'(pc - 7'd24);
      rsel = (j >= 5'd12);
      jj   = rsel ? j - 5'd12 : j;
      k    = jj[3:2];
      case (jj[1:0])
        2'd0:    u = ppj_uop(OP_MUL, rsel ? A_V : A_U, addr_t'({2'd2, k}), A_T);
        2'd1:    u = ppj_uop(OP_NEG, A_T, A_T, A_T);
        2'd2:    u = ppj_uop(OP_ADD, addr_t'({1'b0, rsel, k}), A_T, A_T);
        default: u = ppj_uop(OP_MUL, A_T, A_R, (rsel ? A_J2 : A_J1) + addr_t'(k));
      endcase
    end else if (pc < 7'd51) begin
      u = ppj_uop(OP_MUL, A_X + addr_t'(pc - 7'd48), A_R, A_A0 + addr_t'(pc - 7'd48));
    end else if (pc < 7'd67) begin
      // camera jacobian tails: -(u*a[k]) and -(v*a[k])
      j    = 5'(pc - 7'd51);
      rsel = j[3];
      k    = j[2:1];
      ak   = (k == 2'd3) ? A_R : A_A0 + addr_t'(k);
      if (!j[0]) begin
        u = ppj_uop(OP_MUL, rsel ? A_V : A_U, ak, A_T);
      end else begin
        u = ppj_uop(OP_NEG, A_T, A_T, (rsel ? A_G8 : A_G5) + addr_t'(k));
      end
    end else if (pc < 7'd75) begin
      u = ppj_emit(4'(pc - 7'd66));
    end else begin
      u = ppj_uop(OP_END, A_W, A_W, A_W);
    end
    return u;
  endfunction

endpackage

`default_nettype wire

[design/ppj_alu.sv]
// ----------------------------------------------------------------------------
// ppj_alu
// shared multi-cycle unit: fixed-point multiply in four half-width partial
// products, and reciprocal by bit-serial restoring division, both saturating
// ----------------------------------------------------------------------------
`default_nettype none

module ppj_alu import ppj_pkg::*; #(
  parameter int WORD_BITS = WordBitsDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire alu_req_t                    req_i,
  input  wire logic signed [WORD_BITS-1:0] a_i,
  input  wire logic signed [WORD_BITS-1:0] b_i,
  output logic                             done_o,
  output logic signed [WORD_BITS-1:0]      result_o
);

  localparam int W       = WORD_BITS;
  localparam int H       = (W + 1) / 2;
  localparam int AccBits = 4 * H;
  localparam int QBits   = 2 * FRAC_BITS + 1;
  localparam int QExt    = QBits + W;
  localparam int CntBits = $clog2(QBits);
  localparam logic [W-1:0] WMaxU = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] WMinU = {1'b1, {(W - 1){1'b0}}};

  al_state_e           state_q, state_d;
  logic [W-1:0]        ma_q, mb_q;
  logic                neg_q;
  logic [1:0]          step_q, sh_q;
  logic [2*H-1:0]      pp_q;
  logic [AccBits-1:0]  acc_q;
  logic [W-1:0]        rem_q;
  logic [QBits-1:0]    quo_q;
  logic [CntBits-1:0]  cnt_q;

  logic [H-1:0]        pa, pb;
  logic [2*H-1:0]      prod;
  logic [AccBits-1:0]  pp_shift;
  logic [W:0]          rem_try;
  logic                num_bit;
  logic [AccBits-1:0]  mval;
  logic [QExt-1:0]     qval;
  logic                sat;
  logic [W-1:0]        mag_w;

  // magnitudes of the operands
  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? ~v + W'(1) : v;
  endfunction

  // partial product select and its weight
  always_comb begin
    pa   = step_q[1] ? H'(ma_q >> H) : ma_q[H-1:0];
    pb   = step_q[0] ? H'(mb_q >> H) : mb_q[H-1:0];
    prod = (2 * H)'(pa) * (2 * H)'(pb);
    case (sh_q)
      2'd1:    pp_shift = AccBits'(pp_q) << H;
      2'd2:    pp_shift = AccBits'(pp_q) << (2 * H);
      default: pp_shift = AccBits'(pp_q);
    endcase
  end

  // restoring division step
  always_comb begin
    num_bit = (cnt_q == CntBits'(QBits - 1));
    rem_try = {rem_q, num_bit};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      AL_IDLE: if (req_i.start) state_d = req_i.recip ? AL_DIV : AL_MUL;
      AL_MUL:  if (step_q == 2'd3) state_d = AL_MACC;
      AL_MACC: state_d = AL_FIN;
      AL_DIV:  if (cnt_q == '0) state_d = AL_FIN;
      AL_FIN:  state_d = AL_IDLE;
      default: state_d = AL_IDLE;
    endcase
  end

  // result pack and saturate
  always_comb begin
    done_o = (state_q == AL_FIN);
    mval   = acc_q >> FRAC_BITS;
    qval   = QExt'(quo_q);
    if (sh_q == 2'd3) begin
      sat   = qval > (QExt'(WMaxU) + QExt'(neg_q));
      mag_w = W'(quo_q);
    end else begin
      sat   = mval > (AccBits'(WMaxU) + AccBits'(neg_q));
      mag_w = W'(mval);
    end
    if (sat) begin
      result_o = neg_q ? WMinU : WMaxU;
    end else begin
      result_o = neg_q ? ~mag_w + W'(1) : mag_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers; sh_q of three marks a division
  always_ff @(posedge clk_i) begin
    case (state_q)
      AL_IDLE: begin
        if (req_i.start) begin
          ma_q   <= mag(a_i);
          mb_q   <= mag(b_i);
          neg_q  <= req_i.recip ? a_i[W-1] : a_i[W-1] ^ b_i[W-1];
          step_q <= 2'd0;
          sh_q   <= req_i.recip ? 2'd3 : 2'd0;
          pp_q   <= '0;
          acc_q  <= '0;
          rem_q  <= '0;
          quo_q  <= '0;
          cnt_q  <= CntBits'(QBits - 1);
        end
      end
      AL_MUL: begin
        acc_q  <= acc_q + pp_shift;
        pp_q   <= prod;
        sh_q   <= 2'(step_q[1]) + 2'(step_q[0]);
        step_q <= step_q + 2'd1;
      end
      AL_MACC: acc_q <= acc_q + pp_shift;
      AL_DIV: begin
        if (rem_try >= {1'b0, ma_q}) begin
          rem_q        <= W'(rem_try - {1'b0, ma_q});
          quo_q[cnt_q] <= 1'b1;
        end else begin
          rem_q <= W'(rem_try);
        end
        cnt_q <= cnt_q - CntBits'(1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/ppj_back.sv]
// ----------------------------------------------------------------------------
// ppj_back
// micro-op sequencer over a scratch memory holding matrix, point and
// intermediates; drives the shared alu and the output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "projective_point_projection_jacobian_top_defines.svh"

module ppj_back import ppj_pkg::*; #(
  parameter int WORD_BITS = WordBitsDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       job_valid_i,
  input  wire logic [4*WORD_BITS+3:0]     job_data_i,
  output logic                            job_pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [GroupBits-1:0]            group_o,
  output logic signed [FieldBits-1:0]     value_a_o,
  output logic signed [FieldBits-1:0]     value_b_o,
  output logic signed [FieldBits-1:0]     value_c_o,
  output logic signed [FieldBits-1:0]     value_d_o,
  output logic                            last_o,
  output logic                            zero_depth_o
);

  localparam int W = WORD_BITS;
  localparam int E = ((W > FieldBits) ? W : FieldBits) + 1;
  localparam logic signed [E-1:0] FMax = E'(32'sh7fffffff);
  localparam logic signed [E-1:0] FMin = E'(32'sh80000000);
  localparam logic [W-1:0] WMaxU = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] WMinU = {1'b1, {(W - 1){1'b0}}};

  bk_state_e           state_q, state_d;
  job_e                kind_q;
  logic [RowBits-1:0]  row_q;
  logic [W-1:0]        val_q [4];
  logic [1:0]          cnt_q, cnt_d;
  pc_t                 pc_q, pc_d;
  logic                zd_q, zd_d;
  logic [W-1:0]        mem_q [MemDepth];
  logic [W-1:0]        rd_a_q, rd_b_q, hold_a_q, hold_b_q;

  logic                out_valid_q;
  logic [GroupBits-1:0] out_grp_q;
  logic [FieldBits-1:0] out_a_q, out_b_q, out_c_q, out_d_q;
  logic                out_last_q, out_zd_q;

  uop_t                uop;
  addr_t               ra, rb, waddr;
  logic                we;
  logic [W-1:0]        wdata;
  logic [W:0]          sum;
  logic [W-1:0]        sum_sat, neg_a;
  logic                out_free, out_load;
  alu_req_t            alu_req;
  logic                alu_done;
  logic [W-1:0]        alu_res;

  // saturate a word to the 32-bit result field
  function automatic logic [FieldBits-1:0] to_field(input logic [W-1:0] v);
    logic signed [E-1:0] x;
    x = E'(signed'(v));
    if (x > FMax) return FieldBits'(FMax);
    if (x < FMin) return FieldBits'(FMin);
    return FieldBits'(x);
  endfunction

  ppj_alu #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (rd_a_q),
    .b_i     (rd_b_q),
    .done_o  (alu_done),
    .result_o(alu_res)
  );

  // current micro-op and read addresses
  always_comb begin
    uop = ppj_prog(pc_q);
    if (state_q == BK_EMIT_B || state_q == BK_EMIT_C) begin
      ra = uop.c;
      rb = uop.d;
    end else begin
      ra = uop.a;
      rb = uop.b;
    end
  end

  // saturating add and negate
  always_comb begin
    sum = {rd_a_q[W-1], rd_a_q} + {rd_b_q[W-1], rd_b_q};
    if (sum[W] != sum[W-1]) begin
      sum_sat = sum[W] ? WMinU : WMaxU;
    end else begin
      sum_sat = sum[W-1:0];
    end
    neg_a = (rd_a_q == WMinU) ? WMaxU : ~rd_a_q + W'(1);
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_e'(job_data_i[4*W+3 -: 2]) == JOB_LOAD) ? BK_LOAD : BK_PTWR;
        end
      end
      BK_LOAD:  if (cnt_q == 2'd3) state_d = BK_IDLE;
      BK_PTWR:  if (cnt_q == 2'd2) state_d = BK_FETCH;
      BK_FETCH: state_d = BK_EXEC;
      BK_EXEC: begin
        unique case (uop.kind)
          OP_MUL, OP_RCP:        state_d = BK_WAIT;
          OP_ADD, OP_NEG, OP_BZ: state_d = BK_FETCH;
          OP_CHK:  state_d = (kind_q == JOB_PROJ) ? BK_IDLE : BK_FETCH;
          OP_EMIT: state_d = BK_EMIT_B;
          OP_END:  state_d = BK_IDLE;
          default: state_d = BK_IDLE;
        endcase
      end
      BK_WAIT:   if (alu_done) state_d = BK_FETCH;
      BK_EMIT_B: state_d = BK_EMIT_C;
      BK_EMIT_C: if (out_free) state_d = BK_FETCH;
      default:   state_d = BK_IDLE;
    endcase
  end

  // control outputs, memory write port, counters
  always_comb begin
    job_pop_o     = 1'b0;
    we            = 1'b0;
    waddr         = uop.dst;
    wdata         = alu_res;
    alu_req.start = 1'b0;
    alu_req.recip = (uop.kind == OP_RCP);
    out_load      = 1'b0;
    cnt_d         = cnt_q;
    pc_d          = pc_q;
    zd_d          = zd_q;
    unique case (state_q)
      BK_IDLE: begin
        job_pop_o = job_valid_i;
        cnt_d     = 2'd0;
      end
      BK_LOAD: begin
        we    = 1'b1;
        waddr = addr_t'({row_q, cnt_q});
        wdata = val_q[cnt_q];
        cnt_d = cnt_q + 2'd1;
      end
      BK_PTWR: begin
        we    = 1'b1;
        waddr = A_X + addr_t'(cnt_q);
        wdata = val_q[cnt_q];
        cnt_d = cnt_q + 2'd1;
        pc_d  = '0;
        zd_d  = 1'b0;
      end
      BK_EXEC: begin
        case (uop.kind)
          OP_ADD: begin
            we    = 1'b1;
            wdata = sum_sat;
            pc_d  = pc_q + pc_t'(1);
          end
          OP_NEG: begin
            we    = 1'b1;
            wdata = neg_a;
            pc_d  = pc_q + pc_t'(1);
          end
          OP_MUL, OP_RCP: alu_req.start = 1'b1;
          OP_BZ: begin
            if (rd_a_q == '0) begin
              zd_d = 1'b1;
              pc_d = uop.tgt;
            end else begin
              pc_d = pc_q + pc_t'(1);
            end
          end
          OP_CHK:  pc_d = zd_q ? uop.tgt : pc_q + pc_t'(1);
          default: ;
        endcase
      end
      BK_WAIT: begin
        if (alu_done) begin
          we   = 1'b1;
          pc_d = pc_q + pc_t'(1);
        end
      end
      BK_EMIT_C: begin
        if (out_free) begin
          out_load = 1'b1;
          pc_d     = pc_q + pc_t'(1);
        end
      end
      default: ;
    endcase
  end

  // scratch memory, registered reads
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_a_q <= mem_q[ra];
    rd_b_q <= mem_q[rb];
  end

  // job payload and emit holding registers
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      kind_q <= job_e'(job_data_i[4*W+3 -: 2]);
      row_q  <= job_data_i[4*W+1 -: 2];
      for (int i = 0; i < 4; i++) val_q[i] <= job_data_i[i*W +: W];
    end
    if (state_q == BK_EXEC) begin
      hold_a_q <= rd_a_q;
      hold_b_q <= rd_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
      pc_q    <= '0;
      zd_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pc_q    <= pc_d;
      zd_q    <= zd_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_grp_q  <= uop.grp;
      out_a_q    <= (uop.en[0] && !zd_q) ? to_field(hold_a_q) : '0;
      out_b_q    <= (uop.en[1] && !zd_q) ? to_field(hold_b_q) : '0;
      out_c_q    <= (uop.en[2] && !zd_q) ? to_field(rd_a_q) : '0;
      out_d_q    <= (uop.en[3] && !zd_q) ? to_field(rd_b_q) : '0;
      out_last_q <= (uop.grp == GroupBits'(8)) ||
                    (uop.grp == '0 && kind_q == JOB_PROJ);
      out_zd_q   <= zd_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign group_o      = out_grp_q;
  assign value_a_o    = out_a_q;
  assign value_b_o    = out_b_q;
  assign value_c_o    = out_c_q;
  assign value_d_o    = out_d_q;
  assign last_o       = out_last_q;
  assign zero_depth_o = out_zd_q;

  `PPJ_ASSERT_IMP(a_alu_done_in_wait, alu_done, state_q == BK_WAIT, "alu result outside wait")
  `PPJ_ASSERT_IMP(a_zero_depth_values, out_valid_q && out_zd_q,
    out_a_q == '0 && out_b_q == '0 && out_c_q == '0 && out_d_q == '0,
    "nonzero value on zero depth item")

endmodule

`default_nettype wire

[design/ppj_fifo.sv]
// ----------------------------------------------------------------------------
// ppj_fifo
// short queue between the classifying front and the sequencing back
// ----------------------------------------------------------------------------
`default_nettype none
`include "projective_point_projection_jacobian_top_defines.svh"

module ppj_fifo import ppj_pkg::*; #(
  parameter int DATA_BITS = 4 * WordBitsDef + 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [DATA_BITS-1:0] data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output logic [DATA_BITS-1:0]      data_o
);

  localparam int PtrBits = $clog2(FifoDepth);

  logic [DATA_BITS-1:0] buf_q [FifoDepth];
  logic [PtrBits-1:0]   wr_q, rd_q;
  logic [PtrBits:0]     cnt_q;

  assign full_o  = (cnt_q == (PtrBits + 1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrBits'(1);
      if (pop_i)  rd_q <= rd_q + PtrBits'(1);
      cnt_q <= cnt_q + (PtrBits + 1)'(push_i) - (PtrBits + 1)'(pop_i);
    end
  end

  `PPJ_ASSERT_IMP(a_fifo_no_overflow, push_i, !full_o, "push into full queue")
  `PPJ_ASSERT_IMP(a_fifo_no_underflow, pop_i, valid_o, "pop from empty queue")

endmodule

`default_nettype wire

[design/ppj_front.sv]
// ----------------------------------------------------------------------------
// ppj_front
// accepts items, drops ignored codes, converts fields to words and queues a job
// ----------------------------------------------------------------------------
`default_nettype none

module ppj_front import ppj_pkg::*; #(
  parameter int WORD_BITS = WordBitsDef
) (
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ModeBits-1:0]         mode_i,
  input  wire logic [RowBits-1:0]          row_index_i,
  input  wire logic signed [FieldBits-1:0] val0_i,
  input  wire logic signed [FieldBits-1:0] val1_i,
  input  wire logic signed [FieldBits-1:0] val2_i,
  input  wire logic signed [FieldBits-1:0] val3_i,
  input  wire logic                        fifo_full_i,
  output logic                             push_o,
  output logic [4*WORD_BITS+3:0]           push_data_o
);

  localparam int W = WORD_BITS;
  localparam int E = ((W > FieldBits) ? W : FieldBits) + 1;
  localparam logic signed [E-1:0] WMax = E'({1'b0, {(W - 1){1'b1}}});
  localparam logic signed [E-1:0] WMin = -WMax - E'(1);

  job_e kind;
  logic keep;

  // sign-extend a field and saturate it to the word range
  function automatic logic [W-1:0] to_word(input logic [FieldBits-1:0] v);
    logic signed [E-1:0] x;
    x = E'(signed'(v));
    if (x > WMax) return W'(WMax);
    if (x < WMin) return W'(WMin);
    return W'(x);
  endfunction

  // classify the item
  always_comb begin
    kind = JOB_LOAD;
    keep = 1'b0;
    unique case (mode_i)
      MODE_LOAD: keep = (row_index_i <= ROW_LAST);
      MODE_PROJ: begin
        kind = JOB_PROJ;
        keep = 1'b1;
      end
      MODE_JAC: begin
        kind = JOB_JAC;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall_o  = fifo_full_i;
  assign push_o      = in_valid_i && !fifo_full_i && keep;
  assign push_data_o = {kind, row_index_i, to_word(val3_i), to_word(val2_i),
                        to_word(val1_i), to_word(val0_i)};

endmodule

`default_nettype wire

[design/projective_point_projection_jacobian_top.sv]
// ----------------------------------------------------------------------------
// projective_point_projection_jacobian_top
// projective camera reprojection with point and camera jacobians, fixed point
// ----------------------------------------------------------------------------
// a projection job emits one result; a jacobian job emits the projection result
// and then the jacobian results, nine in all; the shared alu does each multiply
// micro-op as four half-width partial products and the reciprocal micro-op by
// bit-serial restoring division
// reset clears queue, sequencer and output valid; the camera matrix is not cleared
`default_nettype none

module projective_point_projection_jacobian_top import ppj_pkg::*; #(
  parameter int WORD_BITS = WordBitsDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ModeBits-1:0]         mode_i,
  input  wire logic [RowBits-1:0]          row_index_i,
  input  wire logic signed [FieldBits-1:0] val0_i,
  input  wire logic signed [FieldBits-1:0] val1_i,
  input  wire logic signed [FieldBits-1:0] val2_i,
  input  wire logic signed [FieldBits-1:0] val3_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [GroupBits-1:0]             group_o,
  output logic signed [FieldBits-1:0]      value_a_o,
  output logic signed [FieldBits-1:0]      value_b_o,
  output logic signed [FieldBits-1:0]      value_c_o,
  output logic signed [FieldBits-1:0]      value_d_o,
  output logic                             last_o,
  output logic                             zero_depth_o
);

  localparam int JobBits = 4 * WORD_BITS + 4;

  logic               push, full, pop, job_valid;
  logic [JobBits-1:0] push_data, job_data;

  ppj_front #(.WORD_BITS(WORD_BITS)) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .row_index_i(row_index_i),
    .val0_i     (val0_i),
    .val1_i     (val1_i),
    .val2_i     (val2_i),
    .val3_i     (val3_i),
    .fifo_full_i(full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  ppj_fifo #(.DATA_BITS(JobBits)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(job_valid),
    .data_o (job_data)
  );

  ppj_back #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_data_i  (job_data),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .group_o     (group_o),
    .value_a_o   (value_a_o),
    .value_b_o   (value_b_o),
    .value_c_o   (value_c_o),
    .value_d_o   (value_d_o),
    .last_o      (last_o),
    .zero_depth_o(zero_depth_o)
  );

endmodule

`default_nettype wire
